FILE: rtl/tqi_pkg.sv
// Shared types and constants for the table quadratic interpolator.
// No dependencies; imported by every module of the block.
package tqi_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int XW                  = 16;
    localparam int YW                  = 16;
    localparam int COUNT_W             = 7;
    localparam int IDX_W               = 6;
    localparam int MIN_POINTS          = 3;

    localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 7'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Operands handed to the arithmetic unit for one quadratic fit.
    typedef struct packed {
        logic          start;
        logic [XW-1:0] x;
        logic [XW-1:0] x0;
        logic [XW-1:0] x1;
        logic [XW-1:0] x2;
        logic [YW-1:0] y0;
        logic [YW-1:0] y1;
        logic [YW-1:0] y2;
    } arith_req_t;

    // Result of the arithmetic unit, valid for one cycle with done.
    typedef struct packed {
        logic          done;
        logic [YW-1:0] y;
        logic          sat;
    } arith_res_t;

endpackage

FILE: rtl/tqi_table_mem.sv
// Point table storage: one synchronous RAM, x and y packed per entry.
// Depends on tqi_pkg for field widths.
module tqi_table_mem
    import tqi_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int AW    = $clog2(DEFAULT_TABLE_DEPTH)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [XW+YW-1:0]   wdata,
    input  logic [AW-1:0]      raddr,
    output logic [XW+YW-1:0]   rdata
);

    logic [XW+YW-1:0] mem [DEPTH];
    logic [XW+YW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tqi_arith.sv
// Lagrange quadratic evaluation: one shared multiplier stepped through the
// partial products, then a compare and a 16-step restoring divider. Uses tqi_pkg.
module tqi_arith
    import tqi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_res_t res
);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_MUL  = 4'b0010,
        P_CMP  = 4'b0100,
        P_DIV  = 4'b1000
    } phase_t;

    localparam logic [3:0] ST_AB   = 4'd0;
    localparam logic [3:0] ST_ABC  = 4'd1;
    localparam logic [3:0] ST_Y0U  = 4'd2;
    localparam logic [3:0] ST_Y0UV = 4'd3;
    localparam logic [3:0] ST_NEG  = 4'd4;
    localparam logic [3:0] ST_Y1V  = 4'd5;
    localparam logic [3:0] ST_Y1VC = 4'd6;
    localparam logic [3:0] ST_Y2U  = 4'd7;
    localparam logic [3:0] ST_Y2UA = 4'd8;
    localparam logic [3:0] ST_SUM  = 4'd9;
    localparam logic [3:0] ST_P    = 4'd10;

    phase_t        phase_reg, phase_next;
    logic [3:0]    step_reg, step_next;
    logic [XW-1:0] a_reg, b_reg, c_reg, u_reg, v_reg, xd_reg;
    logic [YW-1:0] y0_reg, y1_reg, y2_reg;
    logic [47:0]   t_reg, d_reg;
    logic [63:0]   neg_reg;
    logic [48:0]   s_reg;
    logic [64:0]   p_reg;
    logic [63:0]   r_reg, dv_reg;
    logic [YW-1:0] q_reg;
    logic [3:0]    cnt_reg;
    logic          done_reg;
    logic [YW-1:0] y_reg;
    logic          sat_reg;

    logic [48:0]   mul_a;
    logic [15:0]   mul_b;
    logic [64:0]   prod;
    logic [64:0]   diff;
    logic [63:0]   rem;

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_AB:   begin mul_a = 49'(a_reg);  mul_b = b_reg;  end
            ST_ABC:  begin mul_a = 49'(t_reg);  mul_b = c_reg;  end
            ST_Y0U:  begin mul_a = 49'(y0_reg); mul_b = u_reg;  end
            ST_Y0UV: begin mul_a = 49'(t_reg);  mul_b = v_reg;  end
            ST_NEG:  begin mul_a = 49'(t_reg);  mul_b = b_reg;  end
            ST_Y1V:  begin mul_a = 49'(y1_reg); mul_b = v_reg;  end
            ST_Y1VC: begin mul_a = 49'(t_reg);  mul_b = c_reg;  end
            ST_Y2U:  begin mul_a = 49'(y2_reg); mul_b = u_reg;  end
            ST_Y2UA: begin mul_a = 49'(t_reg);  mul_b = a_reg;  end
            ST_P:    begin mul_a = s_reg;       mul_b = xd_reg; end
            default: begin mul_a = '0;          mul_b = '0;     end
        endcase
    end

    assign prod = 65'(mul_a) * 65'(mul_b);
    assign diff = p_reg - 65'(neg_reg);
    assign rem  = neg_reg - p_reg[63:0];

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        case (phase_reg)
            P_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = P_MUL;
                    step_next  = ST_AB;
                end
            end
            P_MUL:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == ST_P)
                begin
                    phase_next = P_CMP;
                end
            end
            P_CMP:
            begin
                if (p_reg <= 65'(neg_reg) || diff >= 65'({d_reg, 16'h0000}))
                begin
                    phase_next = P_IDLE;
                end
                else
                begin
                    phase_next = P_DIV;
                end
            end
            P_DIV:
            begin
                if (cnt_reg == 4'd0)
                begin
                    phase_next = P_IDLE;
                end
            end
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            step_reg  <= ST_AB;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= 1'b0;
            if (phase_reg == P_CMP && phase_next == P_IDLE)
            begin
                done_reg <= 1'b1;
            end
            if (phase_reg == P_DIV && cnt_reg == 4'd0)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_IDLE:
            begin
                if (req.start)
                begin
                    a_reg  <= req.x1 - req.x0;
                    b_reg  <= req.x2 - req.x1;
                    c_reg  <= req.x2 - req.x0;
                    u_reg  <= req.x - req.x1;
                    v_reg  <= req.x2 - req.x;
                    xd_reg <= req.x - req.x0;
                    y0_reg <= req.y0;
                    y1_reg <= req.y1;
                    y2_reg <= req.y2;
                end
            end
            P_MUL:
            begin
                case (step_reg)
                    ST_ABC:  d_reg   <= prod[47:0];
                    ST_NEG:  neg_reg <= prod[63:0];
                    ST_Y1VC: s_reg   <= prod[48:0];
                    ST_SUM:  s_reg   <= s_reg + 49'(t_reg);
                    ST_P:    p_reg   <= prod;
                    default: t_reg   <= prod[47:0];
                endcase
            end
            P_CMP:
            begin
                if (p_reg <= 65'(neg_reg))
                begin
                    // negative or zero: truncate to 0, flag when at or below -1
                    y_reg   <= '0;
                    sat_reg <= (rem >= 64'(d_reg));
                end
                else if (diff >= 65'({d_reg, 16'h0000}))
                begin
                    y_reg   <= '1;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    r_reg   <= diff[63:0];
                    dv_reg  <= 64'({d_reg, 15'h0000});
                    q_reg   <= '0;
                    cnt_reg <= 4'd15;
                    sat_reg <= 1'b0;
                end
            end
            P_DIV:
            begin
                if (r_reg >= dv_reg)
                begin
                    r_reg <= r_reg - dv_reg;
                end
                q_reg   <= {q_reg[YW-2:0], (r_reg >= dv_reg)};
                dv_reg  <= dv_reg >> 1;
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    y_reg <= {q_reg[YW-2:0], (r_reg >= dv_reg)};
                end
            end
            default: ;
        endcase
    end

    assign res.done = done_reg;
    assign res.y    = y_reg;
    assign res.sat  = sat_reg;

endmodule

FILE: rtl/table_quadratic_interpolator_unit.sv
// Top level of the table quadratic interpolator: request control, table search
// and result register. Depends on tqi_pkg, tqi_table_mem and tqi_arith.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  request  | start, busy               | opcode, point_index, x_value, y_value
//  result   | done (one-cycle strobe)   | interpolated_y, saturated
//  config   | point_count_we            | point_count
//
// A load request leaves busy low. A query request holds busy for the search
// (one RAM read per cycle, so the single RAM read port sets the pace) plus,
// where the search does not settle the result, the arithmetic (the multiply
// and sum steps, one compare and, unless the compare settles the result, 16
// divider steps, then one hand-back), with done in the first idle cycle after.
// Reset clears control state only; table contents are undefined until loaded.
// The receiver cannot stall: done pulses one cycle with the result.
module table_quadratic_interpolator_unit
    import tqi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [IDX_W-1:0]   point_index,
    input  logic [XW-1:0]      x_value,
    input  logic [YW-1:0]      y_value,
    input  logic               point_count_we,
    input  logic [COUNT_W-1:0] point_count,
    output logic               done,
    output logic [YW-1:0]      interpolated_y,
    output logic               saturated
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FIRST = 8'b0000_0010,
        S_LAST  = 8'b0000_0100,
        S_SRCH  = 8'b0000_1000,
        S_RA    = 8'b0001_0000,
        S_RB    = 8'b0010_0000,
        S_RC    = 8'b0100_0000,
        S_CALC  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] pc_reg;
    logic [XW-1:0]      qx_reg, qx_next;
    logic [IW-1:0]      last_reg, last_next;
    logic [IW-1:0]      lo_reg, lo_next;
    logic [IW-1:0]      hi_reg, hi_next;
    logic [IW-1:0]      mid_reg, mid_next;
    logic [YW-1:0]      yfirst_reg, yfirst_next;
    logic [XW+YW-1:0]   e0_reg, e0_next;
    logic [XW+YW-1:0]   e1_reg, e1_next;
    logic               done_reg, done_next;
    logic [YW-1:0]      y_reg, y_next;
    logic               sat_reg, sat_next;

    logic [IW-1:0]      rd_addr;
    logic [XW+YW-1:0]   rd_data;
    logic [XW-1:0]      rd_x;
    logic [YW-1:0]      rd_y;
    logic               mem_we;
    logic [CW-1:0]      pc_w;
    logic [IW-1:0]      n_last;
    logic [IW-1:0]      nlo, nhi;
    logic [IW:0]        msum;
    arith_req_t         areq;
    arith_res_t         ares;

    assign rd_x = rd_data[XW+YW-1:YW];
    assign rd_y = rd_data[YW-1:0];
    assign busy = (state_reg != S_IDLE);

    // Write a point on an accepted load; drop loads beyond the table
    assign mem_we = start && !busy && (opcode == OP_LOAD)
                    && (32'(point_index) < 32'(TABLE_DEPTH));

    // Clamp the point count to 3..TABLE_DEPTH and hold the last index
    assign pc_w = CW'(pc_reg);
    always_comb
    begin
        if (pc_w < CW'(MIN_POINTS))
        begin
            n_last = IW'(MIN_POINTS - 1);
        end
        else if (pc_w > CW'(TABLE_DEPTH))
        begin
            n_last = IW'(TABLE_DEPTH - 1);
        end
        else
        begin
            n_last = IW'(pc_w - CW'(1));
        end
    end

    tqi_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (IW'(point_index)),
        .wdata ({x_value, y_value}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tqi_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .res   (ares)
    );

    always_comb
    begin
        state_next  = state_reg;
        qx_next     = qx_reg;
        last_next   = last_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        yfirst_next = yfirst_reg;
        e0_next     = e0_reg;
        e1_next     = e1_reg;
        done_next   = 1'b0;
        y_next      = y_reg;
        sat_next    = sat_reg;
        rd_addr     = '0;
        nlo         = lo_reg;
        nhi         = hi_reg;
        msum        = '0;

        areq.start = 1'b0;
        areq.x     = qx_reg;
        areq.x0    = e0_reg[XW+YW-1:YW];
        areq.x1    = e1_reg[XW+YW-1:YW];
        areq.x2    = rd_x;
        areq.y0    = e0_reg[YW-1:0];
        areq.y1    = e1_reg[YW-1:0];
        areq.y2    = rd_y;

        case (state_reg)
            S_IDLE:
            begin
                if (start && opcode == OP_QUERY)
                begin
                    qx_next    = x_value;
                    last_next  = n_last;
                    rd_addr    = '0;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (qx_reg <= rd_x)
                begin
                    done_next  = 1'b1;
                    y_next     = rd_y;
                    sat_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    yfirst_next = rd_y;
                    rd_addr     = last_reg;
                    state_next  = S_LAST;
                end
            end
            S_LAST:
            begin
                if (qx_reg >= rd_x)
                begin
                    done_next  = 1'b1;
                    y_next     = rd_y;
                    sat_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = last_reg;
                    mid_next   = last_reg >> 1;
                    rd_addr    = last_reg >> 1;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                // Keep x[lo] <= qx < x[hi]; halve until the interval closes
                if (rd_x <= qx_reg)
                begin
                    nlo = mid_reg;
                end
                else
                begin
                    nhi = mid_reg;
                end
                lo_next = nlo;
                hi_next = nhi;
                if ((nhi - nlo) > IW'(1))
                begin
                    msum       = ({1'b0, nlo} + {1'b0, nhi}) >> 1;
                    mid_next   = msum[IW-1:0];
                    rd_addr    = msum[IW-1:0];
                end
                else if (nlo == '0)
                begin
                    done_next  = 1'b1;
                    y_next     = yfirst_reg;
                    sat_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr    = nlo - IW'(1);
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                e0_next    = rd_data;
                rd_addr    = lo_reg;
                state_next = S_RB;
            end
            S_RB:
            begin
                e1_next    = rd_data;
                rd_addr    = lo_reg + IW'(1);
                state_next = S_RC;
            end
            S_RC:
            begin
                // Exact hit, or a left neighbor not below: answer the middle y
                if (e1_reg[XW+YW-1:YW] == qx_reg
                    || e0_reg[XW+YW-1:YW] >= e1_reg[XW+YW-1:YW])
                begin
                    done_next  = 1'b1;
                    y_next     = e1_reg[YW-1:0];
                    sat_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    areq.start = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (ares.done)
                begin
                    done_next  = 1'b1;
                    y_next     = ares.y;
                    sat_next   = ares.sat;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= POINT_COUNT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (point_count_we)
            begin
                pc_reg <= point_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg     <= qx_next;
        last_reg   <= last_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        yfirst_reg <= yfirst_next;
        e0_reg     <= e0_next;
        e1_reg     <= e1_next;
        y_reg      <= y_next;
        sat_reg    <= sat_next;
    end

    assign done           = done_reg;
    assign interpolated_y = y_reg;
    assign saturated      = sat_reg;

`ifndef ASSERT_OFF
    // A result strobe only ever follows the return to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A load finishes in its own cycle and produces no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_LOAD) |=> (!busy && !done))
        else $error("load request caused work or a result");

    // A query holds the block busy on the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_QUERY) |=> busy)
        else $error("query request not taken up");
`endif

endmodule
